FILE: rtl/mme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, codes and widths of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MAX_DIM_DEF = 32;
	localparam int DIM_W       = 6;
	localparam int IDX_W       = 5;
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 32;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_DONE  = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_ROWS = 2'd0,
		CFG_A_COLS = 2'd1,
		CFG_B_ROWS = 2'd2,
		CFG_B_COLS = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		cmd_t                      cmd;
		logic [IDX_W-1:0]          elem_row;
		logic [IDX_W-1:0]          elem_col;
		logic signed [ELEM_W-1:0]  load_value;
	} in_item_t;

	typedef struct packed {
		kind_t                     kind;
		logic signed [PROD_W-1:0]  read_value;
	} out_item_t;

	typedef struct packed {
		logic [DIM_W-1:0] a_rows;
		logic [DIM_W-1:0] a_cols;
		logic [DIM_W-1:0] b_cols;
	} dims_t;

	typedef struct packed {
		logic  vld;
		kind_t kind;
		logic  use_data;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} eng_state_t;

endpackage : mme_pkg
`default_nettype wire

FILE: rtl/matrix_multiply_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// General matrix multiply C = A x B over Q8.8 elements with Q16.16 results.
// Loads give no result; a read request gives its result strobe through the
// response stage and the result register, and reads and loads can follow
// every cycle while busy is low. A launched compute request holds busy until
// its products are written, one multiply-accumulate per cycle on the operand
// store read port; its result strobe follows in the cycle after busy drops.
// Reset clears control registers, sets dimensions to MAX_DIM (at most 32), stores not cleared.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_top
	import mme_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire in_item_t              request,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [DIM_W-1:0]      cfg_data,
	output logic                       result_valid,
	output out_item_t                  result
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W = DIM_W + 1;
	localparam logic [DIM_W-1:0] DIM_RST = DIM_W'((MAX_DIM < 32) ? MAX_DIM : 32);

	logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [DIM_W-1:0] cfg_clamped;
	dims_t            dims;

	logic             accept;
	logic             in_range;
	logic [AW-1:0]    elem_addr;
	logic             launch;
	logic             eng_active, eng_done;
	logic             op_rd_en;
	logic [AW-1:0]    a_raddr, b_raddr;
	logic signed [ELEM_W-1:0] a_rdata, b_rdata;
	logic             c_we;
	logic [AW-1:0]    c_waddr;
	logic signed [PROD_W-1:0] c_wdata;
	logic             rd_en;
	rsp_t             rsp;

	assign cfg_clamped = (CMP_W'(cfg_data) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= DIM_RST;
			a_cols_q <= DIM_RST;
			b_rows_q <= DIM_RST;
			b_cols_q <= DIM_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_A_ROWS: a_rows_q <= cfg_clamped;
				CFG_A_COLS: a_cols_q <= cfg_clamped;
				CFG_B_ROWS: b_rows_q <= cfg_clamped;
				CFG_B_COLS: b_cols_q <= cfg_clamped;
				default: ;
			endcase
		end
	end

	assign dims.a_rows = a_rows_q;
	assign dims.a_cols = a_cols_q;
	assign dims.b_cols = b_cols_q;

	assign busy      = eng_active;
	assign accept    = start && !busy;
	assign in_range  = (CMP_W'(request.elem_row) < CMP_W'(MAX_DIM))
		&& (CMP_W'(request.elem_col) < CMP_W'(MAX_DIM));
	assign elem_addr = in_range
		? AW'(AW'(request.elem_row) * AW'(MAX_DIM) + AW'(request.elem_col)) : '0;

	assign launch = accept && (request.cmd == CMD_COMPUTE) && (a_cols_q == b_rows_q)
		&& (a_rows_q != '0) && (b_cols_q != '0);
	assign rd_en  = accept && (request.cmd == CMD_READ);

	always_comb begin
		rsp = '0;
		if (eng_done) begin
			rsp.vld  = 1'b1;
			rsp.kind = KIND_DONE;
		end else if (accept) begin
			case (request.cmd)
				CMD_READ: begin
					rsp.vld      = 1'b1;
					rsp.kind     = KIND_READ;
					rsp.use_data = in_range;
				end
				CMD_COMPUTE: begin
					rsp.vld  = !launch;
					rsp.kind = (a_cols_q != b_rows_q) ? KIND_ERROR : KIND_DONE;
				end
				default: rsp = '0;
			endcase
		end
	end

	mme_operand_store #(
		.MAX_DIM(MAX_DIM)
	) u_operand_store (
		.clk     (clk),
		.we_a    (accept && (request.cmd == CMD_LOAD_A) && in_range),
		.we_b    (accept && (request.cmd == CMD_LOAD_B) && in_range),
		.waddr   (elem_addr),
		.wdata   (request.load_value),
		.rd_en   (op_rd_en),
		.a_raddr (a_raddr),
		.b_raddr (b_raddr),
		.a_rdata (a_rdata),
		.b_rdata (b_rdata)
	);

	mme_mac_engine #(
		.MAX_DIM(MAX_DIM)
	) u_mac_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (launch),
		.dims     (dims),
		.active   (eng_active),
		.done     (eng_done),
		.op_rd_en (op_rd_en),
		.a_raddr  (a_raddr),
		.b_raddr  (b_raddr),
		.a_rdata  (a_rdata),
		.b_rdata  (b_rdata),
		.c_we     (c_we),
		.c_waddr  (c_waddr),
		.c_wdata  (c_wdata)
	);

	mme_result_store #(
		.MAX_DIM(MAX_DIM)
	) u_result_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.c_we         (c_we),
		.c_waddr      (c_waddr),
		.c_wdata      (c_wdata),
		.rd_en        (rd_en),
		.raddr        (elem_addr),
		.rsp          (rsp),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule : matrix_multiply_engine_top
`default_nettype wire

FILE: rtl/mme_operand_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_operand_store
// Element stores of matrices A and B: one write port, registered reads.
// ----------------------------------------------------------------------------
module mme_operand_store
	import mme_pkg::*;
#(
	parameter  int MAX_DIM = MAX_DIM_DEF,
	localparam int DEPTH   = MAX_DIM * MAX_DIM,
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        we_a,
	input  wire logic                        we_b,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic signed [ELEM_W-1:0]    wdata,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               a_raddr,
	input  wire logic [AW-1:0]               b_raddr,
	output logic signed [ELEM_W-1:0]         a_rdata,
	output logic signed [ELEM_W-1:0]         b_rdata
);

	logic signed [ELEM_W-1:0] mem_a [DEPTH];
	logic signed [ELEM_W-1:0] mem_b [DEPTH];
	logic signed [ELEM_W-1:0] a_rdata_q;
	logic signed [ELEM_W-1:0] b_rdata_q;

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[waddr] <= wdata;
		end
		if (we_b) begin
			mem_b[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			a_rdata_q <= mem_a[a_raddr];
			b_rdata_q <= mem_b[b_raddr];
		end
	end

	assign a_rdata = a_rdata_q;
	assign b_rdata = b_rdata_q;

endmodule : mme_operand_store
`default_nettype wire

FILE: rtl/mme_mac_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_mac_engine
// Walks rows, columns and inner steps, multiplies operand pairs and
// accumulates each product element, then writes it saturated.
// ----------------------------------------------------------------------------
module mme_mac_engine
	import mme_pkg::*;
#(
	parameter  int MAX_DIM = MAX_DIM_DEF,
	localparam int DEPTH   = MAX_DIM * MAX_DIM,
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        launch,
	input  wire dims_t                       dims,
	output logic                             active,
	output logic                             done,
	output logic                             op_rd_en,
	output logic [AW-1:0]                    a_raddr,
	output logic [AW-1:0]                    b_raddr,
	input  wire logic signed [ELEM_W-1:0]    a_rdata,
	input  wire logic signed [ELEM_W-1:0]    b_rdata,
	output logic                             c_we,
	output logic [AW-1:0]                    c_waddr,
	output logic signed [PROD_W-1:0]         c_wdata
);

	localparam int ACC_W = PROD_W + 1 + $clog2(MAX_DIM + 1);

	eng_state_t state_q;
	logic [DIM_W-1:0] i_q, j_q, k_q;
	logic [DIM_W-1:0] k_end;
	logic             zero_k;
	logic             last_k, last_j, last_i;

	logic                      vld_s1, first_s1, last_s1, zero_s1;
	logic [AW-1:0]             caddr_s1;
	logic signed [PROD_W-1:0]  prod_full;
	logic                      vld_s2, first_s2, last_s2;
	logic [AW-1:0]             caddr_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic                      wr_s3;
	logic [AW-1:0]             caddr_s3;
	logic signed [ACC_W-1:0]   acc_q;

	function automatic logic signed [PROD_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-PROD_W-1:0] hi;
		hi = v[ACC_W-2:PROD_W-1];
		if (!v[ACC_W-1] && (|hi)) begin
			sat_acc = {1'b0, {(PROD_W-1){1'b1}}};
		end else if (v[ACC_W-1] && !(&hi)) begin
			sat_acc = {1'b1, {(PROD_W-1){1'b0}}};
		end else begin
			sat_acc = v[PROD_W-1:0];
		end
	endfunction

	assign zero_k = (dims.a_cols == '0);
	assign k_end  = zero_k ? DIM_W'(1) : dims.a_cols;
	assign last_k = (k_q == k_end - DIM_W'(1));
	assign last_j = (j_q == dims.b_cols - DIM_W'(1));
	assign last_i = (i_q == dims.a_rows - DIM_W'(1));

	assign op_rd_en = (state_q == ST_RUN);
	assign a_raddr  = AW'(AW'(i_q) * AW'(MAX_DIM) + AW'(k_q));
	assign b_raddr  = AW'(AW'(k_q) * AW'(MAX_DIM) + AW'(j_q));
	assign active   = (state_q != ST_IDLE);
	assign done     = (state_q == ST_DRAIN) && !vld_s1 && !vld_s2 && !wr_s3;

	assign prod_full = a_rdata * b_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (launch) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last_k) begin
						k_q <= '0;
						if (last_j) begin
							j_q <= '0;
							if (last_i) begin
								state_q <= ST_DRAIN;
							end else begin
								i_q <= i_q + DIM_W'(1);
							end
						end else begin
							j_q <= j_q + DIM_W'(1);
						end
					end else begin
						k_q <= k_q + DIM_W'(1);
					end
				end
				ST_DRAIN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			wr_s3  <= 1'b0;
		end else begin
			vld_s1 <= op_rd_en;
			vld_s2 <= vld_s1;
			wr_s3  <= vld_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		last_s1  <= last_k;
		zero_s1  <= zero_k;
		caddr_s1 <= AW'(AW'(i_q) * AW'(MAX_DIM) + AW'(j_q));
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		caddr_s2 <= caddr_s1;
		prod_s2  <= zero_s1 ? '0 : prod_full;
		caddr_s3 <= caddr_s2;
		if (vld_s2) begin
			acc_q <= first_s2 ? ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
	end

	assign c_we    = wr_s3;
	assign c_waddr = caddr_s3;
	assign c_wdata = sat_acc(acc_q);

endmodule : mme_mac_engine
`default_nettype wire

FILE: rtl/mme_result_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_result_store
// Product element store with registered read, response stage and the
// result register.
// ----------------------------------------------------------------------------
module mme_result_store
	import mme_pkg::*;
#(
	parameter  int MAX_DIM = MAX_DIM_DEF,
	localparam int DEPTH   = MAX_DIM * MAX_DIM,
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        c_we,
	input  wire logic [AW-1:0]               c_waddr,
	input  wire logic signed [PROD_W-1:0]    c_wdata,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               raddr,
	input  wire rsp_t                        rsp,
	output logic                             result_valid,
	output out_item_t                        result
);

	logic signed [PROD_W-1:0] mem_c [DEPTH];
	logic signed [PROD_W-1:0] rdata_q;
	rsp_t                     rsp_s1;
	logic                     result_valid_q;
	out_item_t                result_q;

	always_ff @(posedge clk) begin
		if (c_we) begin
			mem_c[c_waddr] <= c_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem_c[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_s1         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			rsp_s1         <= rsp;
			result_valid_q <= rsp_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.kind       <= rsp_s1.kind;
		result_q.read_value <= rsp_s1.use_data ? rdata_q : '0;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule : mme_result_store
`default_nettype wire

FILE: rtl/mme_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_checker
// Port-level checks of requests, results and configuration writes, bound to the top level.
// ----------------------------------------------------------------------------
module mme_checker
	import mme_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire in_item_t              request,
	input wire logic                  cfg_we,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [DIM_W-1:0]      cfg_data,
	input wire logic                  result_valid,
	input wire out_item_t             result
);

	logic accept;
	assign accept = start && !busy;

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (request.cmd == CMD_READ) |-> ##2 (result_valid && (result.kind == KIND_READ)))
		else $error("read request without read result");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ((request.cmd == CMD_LOAD_A) || (request.cmd == CMD_LOAD_B))
		|-> ##2 !result_valid)
		else $error("load request produced a result");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |=> (result_valid && (result.kind == KIND_DONE)))
		else $error("compute finished without done result");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind != KIND_READ) |-> (result.read_value == '0))
		else $error("nonzero value on non-read result");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> (!busy && !$isunknown({cfg_index, cfg_data})))
		else $error("configuration written while busy");

endmodule : mme_checker

bind matrix_multiply_engine_top mme_checker u_mme_checker (.*);
`default_nettype wire
